FILE: rtl/ps2md_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
package ps2md_pkg;

    // Header byte bit positions
    localparam int unsigned HDR_ALWAYS_ONE = 3;
    localparam int unsigned HDR_X_SIGN     = 4;
    localparam int unsigned HDR_Y_SIGN     = 5;
    localparam int unsigned HDR_X_OVF      = 6;
    localparam int unsigned HDR_Y_OVF      = 7;

    localparam int unsigned NUM_BUTTONS = 3;
    localparam int unsigned BUTTON_W    = 2;

    // Packet byte positions
    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_X      = 2'd1;
    localparam logic [1:0] POS_Y      = 2'd2;

    // Event kinds
    localparam logic EV_BUTTON = 1'b0;
    localparam logic EV_MOVE   = 1'b1;

    // Register addresses (word index)
    localparam logic REG_ENABLE = 1'b0;

    // Job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One decoded packet: button changes, new button state, movement
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] changes;
        logic [NUM_BUTTONS-1:0] buttons;
        logic                   move;
        logic signed [7:0]      dx;
        logic signed [7:0]      dy;
    } t_job;

    // Queue status toward the back end
    typedef struct packed {
        logic valid;
        t_job job;
    } t_queue_head;

endpackage

FILE: rtl/ps2md_front.sv
// Front end: gathers packet bytes, validates the header and builds event jobs.
module ps2md_front import ps2md_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_enable,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    output logic       o_push,
    output t_job       o_job
);

    logic [1:0]             r_pos;
    logic [1:0]             n_pos;
    logic [7:0]             r_header;
    logic [7:0]             r_xbyte;
    logic [NUM_BUTTONS-1:0] r_prev;
    logic                   pkt_done;
    logic                   pkt_ok;
    logic [NUM_BUTTONS-1:0] buttons;
    logic [NUM_BUTTONS-1:0] changes;
    logic signed [7:0]      dx;
    logic signed [7:0]      dy;

    // Clamp a 9-bit two's complement delta to -127..127
    function automatic logic [7:0] clamp_delta(input logic [7:0] low, input logic neg);
        logic [7:0] res;
        if (neg) begin
            res = (low <= 8'h80) ? 8'h81 : low;
        end else begin
            res = low[7] ? 8'h7F : low;
        end
        return res;
    endfunction

    // Decode the packet completed by the current word
    always_comb begin
        pkt_done = i_accept && i_enable && (r_pos != POS_HEADER) && (r_pos != POS_X);
        pkt_ok   = r_header[HDR_ALWAYS_ONE] && !r_header[HDR_X_OVF] && !r_header[HDR_Y_OVF];
        buttons  = r_header[NUM_BUTTONS-1:0];
        changes  = buttons ^ r_prev;
        dx       = clamp_delta(r_xbyte, r_header[HDR_X_SIGN]);
        dy       = clamp_delta(i_data_byte, r_header[HDR_Y_SIGN]);
        o_job.changes = changes;
        o_job.buttons = buttons;
        o_job.move    = (dx != 8'sd0) || (dy != 8'sd0);
        o_job.dx      = dx;
        o_job.dy      = dy;
        o_push        = pkt_done && pkt_ok && ((changes != '0) || o_job.move);
    end

    // Advance the byte position
    always_comb begin
        n_pos = r_pos;
        if (i_accept && i_enable) begin
            unique case (r_pos)
                POS_HEADER: n_pos = POS_X;
                POS_X:      n_pos = POS_Y;
                default:    n_pos = POS_HEADER;
            endcase
        end
    end

    // Hold position, header, X byte and previous buttons
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_HEADER;
            r_header <= '0;
            r_xbyte  <= '0;
            r_prev   <= '0;
        end else begin
            r_pos <= n_pos;
            if (i_accept && i_enable && (r_pos == POS_HEADER)) begin
                r_header <= i_data_byte;
            end
            if (i_accept && i_enable && (r_pos == POS_X)) begin
                r_xbyte <= i_data_byte;
            end
            if (pkt_done && pkt_ok) begin
                r_prev <= buttons;
            end
        end
    end

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != 2'd3)
        else $error("byte position reached an unused value");
`endif

endmodule

FILE: rtl/ps2md_queue.sv
// Short job queue in flip-flops between the front and back ends.
module ps2md_queue import ps2md_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_job        i_job,
    input  logic        i_pop,
    output logic        o_full,
    output t_queue_head o_head
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full       = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");
`endif

endmodule

FILE: rtl/ps2md_back.sv
// Back end: expands one job into button and move events, one word per cycle while i_stall is low.
module ps2md_back import ps2md_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_queue_head         i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_event_kind,
    output logic [BUTTON_W-1:0] o_button_id,
    output logic                o_button_down,
    output logic signed [7:0]   o_delta_x,
    output logic signed [7:0]   o_delta_y,
    output logic                o_last
);

    t_job                r_work;
    t_job                n_work;
    logic                r_work_valid;
    logic                n_work_valid;
    logic                r_out_valid;
    logic                out_load;
    logic                found;
    logic [BUTTON_W-1:0] pick_id;
    logic                pick_down;
    logic                pick_move;
    logic                work_done;
    logic                r_kind;
    logic [BUTTON_W-1:0] r_id;
    logic                r_down;
    logic signed [7:0]   r_dx;
    logic signed [7:0]   r_dy;
    logic                r_last;

    assign out_load = !r_out_valid || !i_stall;

    // Pick the next event: buttons left to middle, then movement
    always_comb begin
        found     = 1'b0;
        pick_id   = '0;
        pick_down = 1'b0;
        n_work    = r_work;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (!found && r_work.changes[b]) begin
                found            = 1'b1;
                pick_id          = BUTTON_W'(b);
                pick_down        = r_work.buttons[b];
                n_work.changes[b] = 1'b0;
            end
        end
        pick_move = !found;
        if (pick_move) begin
            n_work.move = 1'b0;
        end
        work_done = (n_work.changes == '0) && !n_work.move;
    end

    // Refill the work register from the queue
    always_comb begin
        n_work_valid = r_work_valid;
        o_pop        = 1'b0;
        if (r_work_valid && out_load) begin
            if (work_done) begin
                n_work_valid = i_head.valid;
                o_pop        = i_head.valid;
            end
        end else if (!r_work_valid) begin
            n_work_valid = i_head.valid;
            o_pop        = i_head.valid;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_work_valid <= n_work_valid;
            if (out_load) begin
                r_out_valid <= r_work_valid;
            end
        end
    end

    // Load work and output words
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_head.job;
        end else if (r_work_valid && out_load) begin
            r_work <= n_work;
        end
        if (r_work_valid && out_load) begin
            r_kind <= pick_move ? EV_MOVE : EV_BUTTON;
            r_id   <= pick_id;
            r_down <= pick_down;
            r_dx   <= pick_move ? r_work.dx : 8'sd0;
            r_dy   <= pick_move ? r_work.dy : 8'sd0;
            r_last <= work_done;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_event_kind  = r_kind;
    assign o_button_id   = r_id;
    assign o_button_down = r_down;
    assign o_delta_x     = r_dx;
    assign o_delta_y     = r_dy;
    assign o_last        = r_last;

`ifndef ASSERT_OFF
    a_work_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_work_valid |-> ((r_work.changes != '0) || r_work.move))
        else $error("work register holds a job without events");
    a_button_no_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == EV_BUTTON)) |-> ((r_dx == 8'sd0) && (r_dy == 8'sd0)))
        else $error("button event carries movement");
`endif

endmodule

FILE: rtl/ps2_mouse_packet_decoder.sv
// PS/2 mouse packet decoder top level: register port, front end, job queue, back end.
//
// Takes one raw mouse byte per word and gathers three-byte packets (header, X, Y) while
// the enable register is set; words taken while it is clear are dropped. A byte is
// taken every cycle as long as the two-entry job queue has room; o_stall rises only
// while that queue is full. A complete, valid packet with a button change or movement
// becomes one job holding its button changes and clamped deltas; the back end turns a job
// into 1 to 4 events (button presses or releases left, right, middle, then one move), one
// per cycle while i_stall is low, and marks the final event with o_last. The first event
// passes through the job queue, work register and output register. Packets with header
// bit 3 clear or an overflow bit set give no events and leave the button state alone.
module ps2_mouse_packet_decoder import ps2md_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Byte input
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_data_byte,
    // Event output
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_event_kind,
    output logic [BUTTON_W-1:0] o_button_id,
    output logic                o_button_down,
    output logic signed [7:0]   o_delta_x,
    output logic signed [7:0]   o_delta_y,
    output logic                o_last
);

    logic        r_enable;
    logic        cfg_write;
    logic        in_accept;
    logic        q_full;
    logic        push;
    logic        pop;
    t_job        job;
    t_queue_head head;

    // Register port: single enable bit at word zero
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ENABLE) ? {31'b0, r_enable} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (cfg_write && (paddr[2] == REG_ENABLE)) begin
            r_enable <= pwdata[0];
        end
    end

    // Stall input words while the job queue is full
    assign o_stall   = q_full;
    assign in_accept = i_valid && !o_stall;

    ps2md_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (r_enable),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_job       (job)
    );

    ps2md_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    ps2md_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_event_kind  (o_event_kind),
        .o_button_id   (o_button_id),
        .o_button_down (o_button_down),
        .o_delta_x     (o_delta_x),
        .o_delta_y     (o_delta_y),
        .o_last        (o_last)
    );

endmodule
